/* design/uhid_pkg.sv */
package uhid_pkg;

    // report identifiers
    localparam logic [7:0] RID_STATUS  = 8'h06;
    localparam logic [7:0] RID_BATTERY = 8'h0C;
    localparam logic [7:0] RID_MAINS   = 8'h13;
    localparam logic [7:0] RID_OUT_V   = 8'h14;
    localparam logic [7:0] RID_FLAGS   = 8'h16;
    localparam logic [7:0] RID_IN_V    = 8'h21;

    // quantity kinds
    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_CHARGE  = 4'd1;
    localparam logic [3:0] KIND_RUNTIME = 4'd2;
    localparam logic [3:0] KIND_BATT_MV = 4'd3;
    localparam logic [3:0] KIND_MAINS   = 4'd4;
    localparam logic [3:0] KIND_OUT_MV  = 4'd5;
    localparam logic [3:0] KIND_FLAGS   = 4'd6;
    localparam logic [3:0] KIND_LOAD    = 4'd7;
    localparam logic [3:0] KIND_IN_MV   = 4'd8;

    // status codes
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_OB      = 2'd1;
    localparam logic [1:0] ST_LB      = 2'd2;
    localparam logic [1:0] ST_OL      = 2'd3;

    localparam logic [31:0] FLAG_LB_MASK = 32'h0000_0002;

    localparam int MAX_ITEMS   = 3;
    localparam int ITEM_IDX_W  = 2;
    localparam int MV_W        = 18;
    localparam int COUNT_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MV_W-1:0]    TRK_WINDOW = 18'd5000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

    // one decoded report, as handed from front to back
    typedef struct packed {
        logic                                ok;
        logic [1:0]                          status;
        logic [ITEM_IDX_W-1:0]               num_items;   // 1..3
        logic [MAX_ITEMS-1:0][3:0]           kind;
        logic [MAX_ITEMS-1:0][31:0]          value;
        logic                                trk;         // item 0 goes through tracker
        logic [MV_W-1:0]                     trk_mv;
    } entry_t;

    // whole volts in 90..150 or 200..260
    function automatic logic mv_plausible(input logic [31:0] mv);
        mv_plausible = (mv inside {[32'd90000:32'd150999], [32'd200000:32'd260999]});
    endfunction

endpackage

/* design/uhid_rpt_if.sv */
interface uhid_rpt_if;
    logic       valid;
    logic       ready;
    logic [6:0] report_length;
    logic [7:0] report_id;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;

    modport source (output valid, report_length, report_id, byte1, byte2, byte3, byte4,
                    input ready);
    modport sink   (input valid, report_length, report_id, byte1, byte2, byte3, byte4,
                    output ready);
endinterface

/* design/uhid_res_if.sv */
interface uhid_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  quantity_kind;
    logic [31:0] quantity_value;
    logic [1:0]  unit_status;
    logic        last_of_report;

    modport source (output valid, accepted, quantity_kind, quantity_value, unit_status,
                    last_of_report, input ready);
    modport sink   (input valid, accepted, quantity_kind, quantity_value, unit_status,
                    last_of_report, output ready);
endinterface

/* design/uhid_front.sv */
module uhid_front
    import uhid_pkg::*;
(
    input  logic [6:0] report_length,
    input  logic [7:0] report_id,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    input  logic [7:0] byte3,
    input  logic [7:0] byte4,
    output entry_t     entry
);

    logic [15:0] raw16;
    logic [31:0] flags;
    logic [31:0] ov_c0, ov_c1, ov_c2;
    logic [31:0] iv_c0, iv_c1, iv_c2;

    assign raw16 = {byte2, byte1};
    assign flags = {byte4, byte3, byte2, byte1};

    // output voltage scale candidates, in priority order
    assign ov_c0 = 32'(raw16) * 32'd1000;
    assign ov_c1 = 32'(raw16) * 32'd100;
    assign ov_c2 = 32'(raw16) * 32'd10;

    // input voltage scale candidates
    assign iv_c0 = 32'(byte1) * 32'd1000;
    assign iv_c1 = 32'(byte1) * 32'd10000;
    assign iv_c2 = 32'(byte1) * 32'd20000;

    always_comb
    begin
        logic [15:0] rt_raw;
        rt_raw          = {byte3, byte2};
        entry           = '0;
        entry.status    = ST_OL;
        entry.num_items = ITEM_IDX_W'(1);
        if (report_length != 7'd0)
        begin
            case (report_id)
                RID_STATUS:
                begin
                    entry.ok = (report_length >= 7'd4);
                end
                RID_BATTERY:
                begin
                    if (report_length >= 7'd4)
                    begin
                        entry.ok        = 1'b1;
                        entry.kind[0]   = KIND_CHARGE;
                        entry.value[0]  = 32'(byte1);
                        entry.kind[1]   = KIND_RUNTIME;
                        entry.value[1]  = 32'(rt_raw);
                        entry.num_items = ITEM_IDX_W'(2);
                        if (rt_raw inside {[16'd800:16'd20000]})
                        begin
                            entry.kind[2]   = KIND_BATT_MV;
                            entry.value[2]  = 32'(rt_raw) * 32'd10;
                            entry.num_items = ITEM_IDX_W'(3);
                        end
                    end
                end
                RID_MAINS:
                begin
                    if (report_length >= 7'd2)
                    begin
                        entry.ok       = 1'b1;
                        entry.kind[0]  = KIND_MAINS;
                        entry.value[0] = {31'd0, (byte1 != 8'd0)};
                        if (byte1 == 8'd0)
                            entry.status = ST_OB;
                    end
                end
                RID_OUT_V:
                begin
                    if (report_length >= 7'd3)
                    begin
                        entry.ok = 1'b1;
                        if (mv_plausible(ov_c0))
                        begin
                            entry.trk    = 1'b1;
                            entry.trk_mv = ov_c0[MV_W-1:0];
                        end
                        else if (mv_plausible(ov_c1))
                        begin
                            entry.trk    = 1'b1;
                            entry.trk_mv = ov_c1[MV_W-1:0];
                        end
                        else if (mv_plausible(ov_c2))
                        begin
                            entry.trk    = 1'b1;
                            entry.trk_mv = ov_c2[MV_W-1:0];
                        end
                    end
                end
                RID_FLAGS:
                begin
                    if (report_length >= 7'd5)
                    begin
                        entry.ok       = 1'b1;
                        entry.kind[0]  = KIND_FLAGS;
                        entry.value[0] = flags;
                        if (byte1 <= 8'd100)
                        begin
                            entry.kind[1]   = KIND_LOAD;
                            entry.value[1]  = 32'(byte1);
                            entry.num_items = ITEM_IDX_W'(2);
                        end
                        if ((flags & FLAG_LB_MASK) != 32'd0)
                            entry.status = ST_LB;
                    end
                end
                RID_IN_V:
                begin
                    if (report_length >= 7'd2)
                    begin
                        entry.ok = 1'b1;
                        if (mv_plausible(iv_c0))
                        begin
                            entry.kind[0]  = KIND_IN_MV;
                            entry.value[0] = iv_c0;
                        end
                        else if (mv_plausible(iv_c1))
                        begin
                            entry.kind[0]  = KIND_IN_MV;
                            entry.value[0] = iv_c1;
                        end
                        else if (mv_plausible(iv_c2))
                        begin
                            entry.kind[0]  = KIND_IN_MV;
                            entry.value[0] = iv_c2;
                        end
                    end
                end
                default:
                begin
                    entry.ok = 1'b0;
                end
            endcase
        end
        // rejected: a single all-zero beat
        if (!entry.ok)
        begin
            entry           = '0;
            entry.status    = ST_UNKNOWN;
            entry.num_items = ITEM_IDX_W'(1);
        end
    end

endmodule

/* design/uhid_queue.sv */
module uhid_queue
    import uhid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* design/uhid_back.sv */
module uhid_back
    import uhid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head_entry,
    output logic        pop,
    uhid_res_if.source  res
);

    logic                  out_valid_reg;
    logic                  out_acc_reg;
    logic [3:0]            out_kind_reg;
    logic [31:0]           out_value_reg;
    logic [1:0]            out_status_reg;
    logic                  out_last_reg;

    logic [ITEM_IDX_W-1:0] idx_reg, idx_next;

    logic                  trk_seen_reg, trk_seen_next;
    logic [MV_W-1:0]       trk_last_reg, trk_last_next;
    logic [COUNT_W-1:0]    trk_count_reg, trk_count_next;

    logic                  load;
    logic                  is_last;
    logic                  use_trk;
    logic                  confirm;
    logic [MV_W-1:0]       diff;
    logic [3:0]            item_kind;
    logic [31:0]           item_value;

    assign load    = head_valid && (!out_valid_reg || res.ready);
    assign is_last = (idx_reg == head_entry.num_items - 1'b1);
    assign pop     = load && is_last;
    assign use_trk = head_entry.trk && (idx_reg == '0);

    assign diff = (trk_last_reg > head_entry.trk_mv) ? (trk_last_reg - head_entry.trk_mv)
                                                     : (head_entry.trk_mv - trk_last_reg);

    // repeat tracker: updated once, when item 0 of a tracked report is loaded
    always_comb
    begin
        trk_seen_next  = trk_seen_reg;
        trk_last_next  = trk_last_reg;
        trk_count_next = trk_count_reg;
        confirm        = 1'b0;
        if (load && use_trk)
        begin
            trk_seen_next = 1'b1;
            trk_last_next = head_entry.trk_mv;
            if (!trk_seen_reg)
                trk_count_next = COUNT_W'(1);
            else if (diff <= TRK_WINDOW)
                trk_count_next = (trk_count_reg < COUNT_MAX) ? trk_count_reg + 1'b1
                                                             : trk_count_reg;
            else
                trk_count_next = COUNT_W'(1);
            confirm = trk_seen_reg && (trk_count_next >= COUNT_W'(2));
        end
    end

    always_comb
    begin
        item_kind  = head_entry.kind[idx_reg];
        item_value = head_entry.value[idx_reg];
        if (use_trk)
        begin
            item_kind  = confirm ? KIND_OUT_MV : KIND_NONE;
            item_value = confirm ? 32'(head_entry.trk_mv) : 32'd0;
        end
        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            trk_seen_reg  <= 1'b0;
            trk_last_reg  <= '0;
            trk_count_reg <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            idx_reg       <= idx_next;
            trk_seen_reg  <= trk_seen_next;
            trk_last_reg  <= trk_last_next;
            trk_count_reg <= trk_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_acc_reg    <= head_entry.ok;
            out_kind_reg   <= item_kind;
            out_value_reg  <= item_value;
            out_status_reg <= head_entry.status;
            out_last_reg   <= is_last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.accepted       = out_acc_reg;
    assign res.quantity_kind  = out_kind_reg;
    assign res.quantity_value = out_value_reg;
    assign res.unit_status    = out_status_reg;
    assign res.last_of_report = out_last_reg;

endmodule

/* design/ups_hid_report_decoder.sv */
// UPS HID report decoder.
// rpt (sink): one beat per HID interrupt report - length, identifier and
//   the first four payload bytes. Taken whenever the report queue has room.
// res (source): one beat per decoded quantity, 1 to 3 beats per report;
//   the final beat of a report has last_of_report set. Rejected reports
//   give a single all-zero beat with last_of_report set.
// Path: report beat into the queue, then queue head into the output register.
// Throughput: one result beat per cycle while res.ready is high, so a report
//   occupies the back end until its result beats (1..3) are out. Reports are accepted
//   back to back while the 2-entry queue between front and back has room.
// Reset: clears the queue, the output valid flag and the output-voltage
//   repeat tracker.
// Stall: when res.ready is low the output register holds its beat; the
//   back end stops, the queue fills and rpt.ready drops once it is full.
module ups_hid_report_decoder
    import uhid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    uhid_rpt_if.sink   rpt,
    uhid_res_if.source res
);

    entry_t dec_entry;
    entry_t head_entry;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   head_valid;

    // front: classify and decode the report
    uhid_front u_front (
        .report_length (rpt.report_length),
        .report_id     (rpt.report_id),
        .byte1         (rpt.byte1),
        .byte2         (rpt.byte2),
        .byte3         (rpt.byte3),
        .byte4         (rpt.byte4),
        .entry         (dec_entry)
    );

    assign rpt.ready = !q_full;
    assign q_push    = rpt.valid && !q_full;

    uhid_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (dec_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back: tracker and beat serialization
    uhid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .res        (res)
    );

endmodule

/* dv/testbench.sv */
module testbench
    import uhid_pkg::*;
();

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    // first result beat follows the report beat through the queue; give it slack
    localparam int DRAIN_CYCLES   = 8;
    // longest legal silence is the output-stall test's hold plus a few gaps
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [31:0] RUNTIME_MIN = 32'd800;
    localparam logic [31:0] RUNTIME_MAX = 32'd20000;

    // one report beat; field order matches {len, id, b1, b2, b3, b4}
    typedef struct packed {
        logic [6:0] len;
        logic [7:0] id;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
    } report_t;

    // one result beat as the block should emit it
    typedef struct packed {
        logic        accepted;
        logic [3:0]  kind;
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    uhid_rpt_if rpt ();
    uhid_res_if res ();

    ups_hid_report_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rpt   (rpt),
        .res   (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result beats still owed by the block, oldest first
    result_beat_t decoded_quantities [$];
    int unsigned  mismatch_count = 0;

    // private copy of the output-voltage repeat tracker
    bit           trk_seen    = 1'b0;
    logic [17:0]  trk_last_mv = '0;
    logic [7:0]   trk_count   = '0;

    // knobs shared by the sender, the receiver and the tests
    bit           sender_idle_en       = 1'b1;
    bit           receiver_idle_en     = 1'b1;
    int unsigned  receiver_hold_cycles = 0;
    int           mains_volts          = 230;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // whole volts inside one of the two mains windows
    function automatic bit volts_plausible(logic [31:0] mv);
        int unsigned volts;
        volts = mv / 1000;
        return (volts >= 90 && volts <= 150) || (volts >= 200 && volts <= 260);
    endfunction

    // scale factors are tried in order; the first plausible product wins
    function automatic bit pick_scale(input logic [31:0] raw, input int unsigned f0,
                                      input int unsigned f1, input int unsigned f2,
                                      output logic [31:0] mv);
        mv = raw * f0;
        if (volts_plausible(mv))
            return 1'b1;
        mv = raw * f1;
        if (volts_plausible(mv))
            return 1'b1;
        mv = raw * f2;
        return volts_plausible(mv);
    endfunction

    // feeds one plausible reading; true once two in a row agree within the window
    function automatic bit tracker_confirms(logic [31:0] mv);
        logic [31:0] delta;
        if (!trk_seen)
        begin
            trk_seen    = 1'b1;
            trk_last_mv = mv[17:0];
            trk_count   = 8'd1;
            return 1'b0;
        end
        delta = (trk_last_mv > mv) ? trk_last_mv - mv : mv - trk_last_mv;
        if (delta <= TRK_WINDOW)
        begin
            if (trk_count < COUNT_MAX)
                trk_count++;
        end
        else
            trk_count = 8'd1;
        trk_last_mv = mv[17:0];
        return trk_count >= 8'd2;
    endfunction

    function automatic result_beat_t quantity(logic [3:0] kind, logic [31:0] value);
        result_beat_t beat;
        beat          = '0;
        beat.accepted = 1'b1;
        beat.kind     = kind;
        beat.value    = value;
        return beat;
    endfunction

    // works out every result beat one accepted report beat should cause
    function automatic void decode_report(report_t r);
        result_beat_t beats [$];
        result_beat_t beat;
        logic [31:0]  raw;
        logic [31:0]  mv;
        logic [31:0]  flags;
        logic [1:0]   status;
        bit           ok;
        ok     = 1'b0;
        status = ST_OL;
        if (r.len != 0)
        begin
            case (r.id)
                RID_STATUS:
                    ok = (r.len >= 4);
                RID_BATTERY:
                    if (r.len >= 4)
                    begin
                        ok  = 1'b1;
                        raw = {16'd0, r.b3, r.b2};
                        beats.push_back(quantity(KIND_CHARGE, {24'd0, r.b1}));
                        beats.push_back(quantity(KIND_RUNTIME, raw));
                        if (raw >= RUNTIME_MIN && raw <= RUNTIME_MAX)
                            beats.push_back(quantity(KIND_BATT_MV, raw * 10));
                    end
                RID_MAINS:
                    if (r.len >= 2)
                    begin
                        ok = 1'b1;
                        beats.push_back(quantity(KIND_MAINS, {31'd0, r.b1 != 8'd0}));
                        if (r.b1 == 8'd0)
                            status = ST_OB;
                    end
                RID_OUT_V:
                    if (r.len >= 3)
                    begin
                        ok  = 1'b1;
                        raw = {16'd0, r.b2, r.b1};
                        if (pick_scale(raw, 1000, 100, 10, mv))
                            if (tracker_confirms(mv))
                                beats.push_back(quantity(KIND_OUT_MV, mv));
                    end
                RID_FLAGS:
                    if (r.len >= 5)
                    begin
                        ok    = 1'b1;
                        flags = {r.b4, r.b3, r.b2, r.b1};
                        beats.push_back(quantity(KIND_FLAGS, flags));
                        if (r.b1 <= 8'd100)
                            beats.push_back(quantity(KIND_LOAD, {24'd0, r.b1}));
                        if ((flags & FLAG_LB_MASK) != 0)
                            status = ST_LB;
                    end
                RID_IN_V:
                    if (r.len >= 2)
                    begin
                        ok = 1'b1;
                        if (pick_scale({24'd0, r.b1}, 1000, 10000, 20000, mv))
                            beats.push_back(quantity(KIND_IN_MV, mv));
                    end
                default:
                    ok = 1'b0;
            endcase
        end

        // rejected: one all-zero beat, tracker untouched
        if (!ok)
        begin
            beat      = '0;
            beat.last = 1'b1;
            decoded_quantities.push_back(beat);
            return;
        end
        if (beats.size() == 0)
            beats.push_back(quantity(KIND_NONE, 32'd0));
        for (int i = 0; i < beats.size(); i++)
        begin
            beat        = beats[i];
            beat.status = status;
            beat.last   = (i == beats.size() - 1);
            decoded_quantities.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------
    // Report sender: drives at the falling edge, sees acceptance at the rising edge
    // ------------------------------------------------------------------

    // entered and left at a falling edge; valid stays up across back-to-back beats
    task automatic send_report(report_t r);
        int unsigned gap;
        gap = sender_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            rpt.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rpt.valid         <= 1'b1;
        rpt.report_length <= r.len;
        rpt.report_id     <= r.id;
        rpt.byte1         <= r.b1;
        rpt.byte2         <= r.b2;
        rpt.byte3         <= r.b3;
        rpt.byte4         <= r.b4;
        do
            @(posedge clk);
        while (!rpt.ready);
        decode_report(r);
        @(negedge clk);
    endtask

    // drop valid, then let every owed beat come out and the pipe settle
    task automatic wait_drained();
        rpt.valid <= 1'b0;
        while (decoded_quantities.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // mostly well-formed reports with content steered at the thresholds,
    // plus some noise and some cut-short reports
    function automatic report_t random_report();
        report_t     r;
        int unsigned min_len;
        int unsigned mult;
        {r.b1, r.b2, r.b3, r.b4} = $urandom;
        r.id  = 8'($urandom);
        r.len = 7'($urandom_range(0, 64));
        if ($urandom_range(0, 99) < 8)
            return r;
        case ($urandom_range(0, 5))
            0:
            begin
                r.id    = RID_STATUS;
                min_len = 4;
            end
            1:
            begin
                r.id    = RID_BATTERY;
                min_len = 4;
                // runtime around the battery-voltage window edges
                if ($urandom_range(0, 1) == 1)
                    {r.b3, r.b2} = 16'($urandom_range(700, 20100));
            end
            2:
            begin
                r.id    = RID_MAINS;
                min_len = 2;
                if ($urandom_range(0, 2) == 0)
                    r.b1 = 8'd0;
            end
            3:
            begin
                r.id    = RID_OUT_V;
                min_len = 3;
                // mostly a drifting mains level so the tracker confirms now and then
                if ($urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 9) == 0)
                        mains_volts = $urandom_range(0, 1) ? $urandom_range(90, 150)
                                                           : $urandom_range(200, 260);
                    else
                        mains_volts += int'($urandom_range(0, 12)) - 6;
                    if (mains_volts < 80 || mains_volts > 270)
                        mains_volts = 230;
                    case ($urandom_range(0, 2))
                        0:       mult = 1;
                        1:       mult = 10;
                        default: mult = 100;
                    endcase
                    {r.b2, r.b1} = 16'(mains_volts * mult + $urandom_range(0, mult - 1));
                end
            end
            4:
            begin
                r.id    = RID_FLAGS;
                min_len = 5;
                if ($urandom_range(0, 1) == 1)
                    r.b1 = 8'($urandom_range(0, 100));
            end
            default:
            begin
                r.id    = RID_IN_V;
                min_len = 2;
                // small bytes reach the x10000 and x20000 scales
                if ($urandom_range(0, 1) == 1)
                    r.b1 = 8'($urandom_range(0, 30));
            end
        endcase
        if ($urandom_range(0, 99) < 6)
            r.len = 7'($urandom_range(0, min_len - 1));
        else
            r.len = 7'($urandom_range(min_len, 64));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result receiver: one stall draw per beat, plus an optional long hold
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_hold_cycles > 0)
            begin
                res.ready <= 1'b0;
                repeat (receiver_hold_cycles) @(negedge clk);
                receiver_hold_cycles = 0;
            end
            stall = receiver_idle_en ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every taken result beat against the oldest owed one
    // ------------------------------------------------------------------
    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (res.valid && res.ready)
        begin
            if (decoded_quantities.size() == 0)
            begin
                $display("%0t: result beat expected none actual kind %0d value %0h",
                         $time, res.quantity_kind, res.quantity_value);
                mismatch_count++;
            end
            else
            begin
                want = decoded_quantities.pop_front();
                check_field("accepted", want.accepted, res.accepted);
                check_field("quantity_kind", want.kind, res.quantity_kind);
                check_field("quantity_value", want.value, res.quantity_value);
                check_field("unit_status", want.status, res.unit_status);
                check_field("last_of_report", want.last, res.last_of_report);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat moving on either side
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rpt.valid && rpt.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // zero length, unknown identifiers, and lengths one short of the minimum
    task automatic test_rejected_reports();
        send_report({7'd0,  RID_BATTERY, 8'h55, 8'h20, 8'h03, 8'h00});
        send_report({7'd64, 8'h00,       8'h00, 8'h00, 8'h00, 8'h00});
        send_report({7'd64, 8'hFF,       8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_report({7'd3,  RID_STATUS,  8'h01, 8'h02, 8'h03, 8'h04});
        send_report({7'd2,  RID_OUT_V,   8'hE6, 8'h00, 8'h00, 8'h00});
        send_report({7'd4,  RID_FLAGS,   8'h02, 8'h00, 8'h00, 8'h00});
    endtask

    // each identifier, with the value thresholds and byte extremes
    task automatic test_report_decoding();
        // accepted but nothing to report
        send_report({7'd4,  RID_STATUS,  8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // runtime just below, at both ends of, and above the battery window
        send_report({7'd4,  RID_BATTERY, 8'hFF, 8'h1F, 8'h03, 8'h00});
        send_report({7'd64, RID_BATTERY, 8'h00, 8'h20, 8'h03, 8'hFF});
        send_report({7'd4,  RID_BATTERY, 8'h64, 8'h20, 8'h4E, 8'h00});
        send_report({7'd4,  RID_BATTERY, 8'h80, 8'hFF, 8'hFF, 8'h00});
        // mains absent puts the unit on battery
        send_report({7'd2,  RID_MAINS,   8'h00, 8'hFF, 8'hFF, 8'hFF});
        send_report({7'd2,  RID_MAINS,   8'hFF, 8'h00, 8'h00, 8'h00});
        // load at its limit, low battery, all flags, load just past the limit
        send_report({7'd5,  RID_FLAGS,   8'h64, 8'h00, 8'h00, 8'h00});
        send_report({7'd5,  RID_FLAGS,   8'h02, 8'h00, 8'h00, 8'h80});
        send_report({7'd64, RID_FLAGS,   8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_report({7'd5,  RID_FLAGS,   8'h65, 8'h00, 8'h00, 8'h00});
        // input voltage on each scale, then no plausible scale at all
        send_report({7'd2,  RID_IN_V,    8'hE6, 8'h00, 8'h00, 8'h00});
        send_report({7'd2,  RID_IN_V,    8'h0C, 8'h00, 8'h00, 8'h00});
        send_report({7'd2,  RID_IN_V,    8'h06, 8'h00, 8'h00, 8'h00});
        send_report({7'd2,  RID_IN_V,    8'h00, 8'hFF, 8'hFF, 8'hFF});
    endtask

    // output voltage: implausible, arm, confirm at exactly 5 V, break, confirm
    task automatic test_output_tracker();
        send_report({7'd3,  RID_OUT_V,   8'h00, 8'h00, 8'h00, 8'h00});
        send_report({7'd3,  RID_OUT_V,   8'hE6, 8'h00, 8'h00, 8'h00});  // 230 x1000
        send_report({7'd3,  RID_OUT_V,   8'h2E, 8'h09, 8'h00, 8'h00});  // 2350 x100
        send_report({7'd3,  RID_OUT_V,   8'h24, 8'h5E, 8'h00, 8'h00});  // 24100 x10
        send_report({7'd3,  RID_OUT_V,   8'hF1, 8'h00, 8'h00, 8'h00});  // 241 x1000
    endtask

    task automatic test_random_reports(int unsigned count, bit send_idle, bit sink_idle);
        sender_idle_en   = send_idle;
        receiver_idle_en = sink_idle;
        repeat (count) send_report(random_report());
    endtask

    // hold the output long enough that the queue fills and report ready drops
    task automatic test_output_stall();
        wait_drained();
        sender_idle_en       = 1'b0;
        receiver_hold_cycles = 80;
        repeat (12) send_report(random_report());
        sender_idle_en       = 1'b1;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        rpt.valid         = 1'b0;
        rpt.report_length = '0;
        rpt.report_id     = '0;
        rpt.byte1         = '0;
        rpt.byte2         = '0;
        rpt.byte3         = '0;
        rpt.byte4         = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_rejected_reports();
        test_report_decoding();
        test_output_tracker();
        test_random_reports(300, 1'b1, 1'b1);
        test_random_reports(70, 1'b0, 1'b0);   // full-rate stretch
        test_random_reports(35, 1'b1, 1'b0);
        test_random_reports(35, 1'b0, 1'b1);
        test_output_stall();
        wait_drained();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
design/uhid_pkg.sv
design/uhid_rpt_if.sv
design/uhid_res_if.sv
design/uhid_front.sv
design/uhid_queue.sv
design/uhid_back.sv
design/ups_hid_report_decoder.sv
dv/testbench.sv
